// ===== src/lco_pkg.sv =====
// Shared constants, types and control structs of the line clip outcode block.
`default_nettype none
package lco_pkg;

   localparam int MAX_CLIPS  = 4;
   localparam int CLIP_CNT_W = $clog2(MAX_CLIPS + 1);

   localparam int COORD_W    = 16;
   localparam int DIV_STEPS  = 32;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam logic [3:0] OC_LEFT   = 4'd1;
   localparam logic [3:0] OC_RIGHT  = 4'd2;
   localparam logic [3:0] OC_BOTTOM = 4'd4;
   localparam logic [3:0] OC_TOP    = 4'd8;

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_LEFT   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_RIGHT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_TOP    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_BOTTOM = 2'd3;

   localparam logic signed [COORD_W-1:0] WINDOW_LEFT_RST   = 16'sd0;
   localparam logic signed [COORD_W-1:0] WINDOW_RIGHT_RST  = 16'sd127;
   localparam logic signed [COORD_W-1:0] WINDOW_TOP_RST    = 16'sd0;
   localparam logic signed [COORD_W-1:0] WINDOW_BOTTOM_RST = 16'sd63;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_WRITE,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic mark_reject;
      logic setup;
      logic mult;
      logic div_start;
      logic writeback;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic                  codes_clear;
      logic                  reject;
      logic                  budget_done;
      logic                  div_busy;
      logic                  div_done;
      logic [CLIP_CNT_W-1:0] clips_used;
   } dp_status_type;

endpackage
`default_nettype wire

// ===== src/lco_req_if.sv =====
// Segment request channel: valid/ready handshake with two endpoints.
`default_nettype none
interface lco_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [lco_pkg::COORD_W-1:0]   start_x;
   logic signed [lco_pkg::COORD_W-1:0]   start_y;
   logic signed [lco_pkg::COORD_W-1:0]   end_x;
   logic signed [lco_pkg::COORD_W-1:0]   end_y;

   modport source (output valid, start_x, start_y, end_x, end_y, input ready);
   modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface
`default_nettype wire

// ===== src/lco_rsp_if.sv =====
// Clip result channel: valid/ready handshake with visibility and clipped endpoints.
`default_nettype none
interface lco_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 visible;
   logic signed [lco_pkg::COORD_W-1:0]   clip_start_x;
   logic signed [lco_pkg::COORD_W-1:0]   clip_start_y;
   logic signed [lco_pkg::COORD_W-1:0]   clip_end_x;
   logic signed [lco_pkg::COORD_W-1:0]   clip_end_y;

   modport source (output valid, visible, clip_start_x, clip_start_y, clip_end_x,
                   clip_end_y, input ready);
   modport sink (input valid, visible, clip_start_x, clip_start_y, clip_end_x,
                 clip_end_y, output ready);
endinterface
`default_nettype wire

// ===== src/lco_divider.sv =====
// Restoring serial divider, one quotient bit per cycle, signed low quotient bits out.
`default_nettype none
module lco_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [15:0] divisor,
   input  wire logic        negate,
   output logic             busy,
   output logic             done,
   output logic [15:0]      quotient
);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [lco_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [15:0]                    rem_ff, rem_in;
   logic [31:0]                    quo_ff, quo_in;
   logic [15:0]                    dsr_ff, dsr_in;
   logic                           neg_ff, neg_in;
   logic [16:0]                    trial;
   logic [16:0]                    diff;
   logic                           fits;

   assign trial = {rem_ff, quo_ff[31]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
         neg_in  = negate;
      end else if (busy_ff) begin
         rem_in = fits ? diff[15:0] : trial[15:0];
         quo_in = {quo_ff[30:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == lco_pkg::DIV_CNT_W'(lco_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      neg_ff <= neg_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = neg_ff ? (16'd0 - quo_ff[15:0]) : quo_ff[15:0];

endmodule
`default_nettype wire

// ===== src/lco_datapath.sv =====
// Window registers, endpoint registers, outcodes, clip operand setup, multiplier and divider.
`default_nettype none
module lco_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire lco_pkg::ctrl_cmd_type               cmd,
   output lco_pkg::dp_status_type                   status,
   input  wire logic                                csr_write_enable,
   input  wire logic [lco_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [lco_pkg::COORD_W-1:0]         csr_write_data,
   input  wire logic signed [lco_pkg::COORD_W-1:0]  in_start_x,
   input  wire logic signed [lco_pkg::COORD_W-1:0]  in_start_y,
   input  wire logic signed [lco_pkg::COORD_W-1:0]  in_end_x,
   input  wire logic signed [lco_pkg::COORD_W-1:0]  in_end_y,
   output logic                                     out_visible,
   output logic signed [lco_pkg::COORD_W-1:0]       out_start_x,
   output logic signed [lco_pkg::COORD_W-1:0]       out_start_y,
   output logic signed [lco_pkg::COORD_W-1:0]       out_end_x,
   output logic signed [lco_pkg::COORD_W-1:0]       out_end_y
);

   logic signed [15:0] win_left_ff, win_right_ff, win_top_ff, win_bottom_ff;
   logic signed [15:0] x1_ff, y1_ff, x2_ff, y2_ff;
   logic               visible_ff;
   logic [lco_pkg::CLIP_CNT_W-1:0] count_ff;

   logic signed [16:0] num_ff, num_in;
   logic signed [16:0] mul_ff, mul_in;
   logic signed [16:0] den_ff, den_in;
   logic signed [15:0] base_ff, base_in;
   logic signed [15:0] edge_ff, edge_in;
   logic               axis_y_ff, axis_y_in;
   logic               first_ff, first_in;
   logic signed [33:0] product_ff;

   logic               res_visible_ff;
   logic signed [15:0] res_sx_ff, res_sy_ff, res_ex_ff, res_ey_ff;

   logic [3:0]         c1, c2, c_sel;
   logic signed [16:0] dx, dy;
   logic [33:0]        prod_mag;
   logic [16:0]        den_mag;
   logic               quot_neg;
   logic               div_busy, div_done;
   logic [15:0]        div_quot;
   logic [15:0]        q16;
   logic signed [15:0] new_val;

   function automatic logic [3:0] outcode(input logic signed [15:0] x,
                                          input logic signed [15:0] y,
                                          input logic signed [15:0] wl,
                                          input logic signed [15:0] wr,
                                          input logic signed [15:0] wt,
                                          input logic signed [15:0] wb);
      logic [3:0] c;
      c = 4'd0;
      if (x < wl) c = lco_pkg::OC_LEFT;
      else if (x > wr) c = lco_pkg::OC_RIGHT;
      if (y > wb) c = c | lco_pkg::OC_BOTTOM;
      else if (y < wt) c = c | lco_pkg::OC_TOP;
      return c;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         win_left_ff   <= lco_pkg::WINDOW_LEFT_RST;
         win_right_ff  <= lco_pkg::WINDOW_RIGHT_RST;
         win_top_ff    <= lco_pkg::WINDOW_TOP_RST;
         win_bottom_ff <= lco_pkg::WINDOW_BOTTOM_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            lco_pkg::CSR_WINDOW_LEFT:   win_left_ff   <= csr_write_data;
            lco_pkg::CSR_WINDOW_RIGHT:  win_right_ff  <= csr_write_data;
            lco_pkg::CSR_WINDOW_TOP:    win_top_ff    <= csr_write_data;
            lco_pkg::CSR_WINDOW_BOTTOM: win_bottom_ff <= csr_write_data;
         endcase
      end
   end

   assign c1 = outcode(x1_ff, y1_ff, win_left_ff, win_right_ff, win_top_ff, win_bottom_ff);
   assign c2 = outcode(x2_ff, y2_ff, win_left_ff, win_right_ff, win_top_ff, win_bottom_ff);
   assign c_sel = (c1 != 4'd0) ? c1 : c2;
   assign dx = {x2_ff[15], x2_ff} - {x1_ff[15], x1_ff};
   assign dy = {y2_ff[15], y2_ff} - {y1_ff[15], y1_ff};

   // clip operands; the intersection is always based at the first endpoint
   always_comb begin
      first_in = c1 != 4'd0;
      base_in  = x1_ff;
      num_in   = dx;
      den_in   = dy;
      edge_in  = win_bottom_ff;
      mul_in   = {win_bottom_ff[15], win_bottom_ff} - {y1_ff[15], y1_ff};
      axis_y_in = 1'b1;
      priority if ((c_sel & lco_pkg::OC_TOP) != 4'd0) begin
         edge_in = win_top_ff;
         mul_in  = {win_top_ff[15], win_top_ff} - {y1_ff[15], y1_ff};
      end else if ((c_sel & lco_pkg::OC_LEFT) != 4'd0) begin
         axis_y_in = 1'b0;
         base_in   = y1_ff;
         num_in    = dy;
         den_in    = dx;
         edge_in   = win_left_ff;
         mul_in    = {win_left_ff[15], win_left_ff} - {x1_ff[15], x1_ff};
      end else if ((c_sel & lco_pkg::OC_RIGHT) != 4'd0) begin
         axis_y_in = 1'b0;
         base_in   = y1_ff;
         num_in    = dy;
         den_in    = dx;
         edge_in   = win_right_ff;
         mul_in    = {win_right_ff[15], win_right_ff} - {x1_ff[15], x1_ff};
      end else begin
         edge_in = win_bottom_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         num_ff    <= num_in;
         mul_ff    <= mul_in;
         den_ff    <= den_in;
         base_ff   <= base_in;
         edge_ff   <= edge_in;
         axis_y_ff <= axis_y_in;
         first_ff  <= first_in;
      end
      if (cmd.mult) begin
         product_ff <= num_ff * mul_ff;
      end
   end

   // magnitude of the product stays below 2^32
   assign prod_mag = product_ff[33] ? (34'd0 - product_ff) : product_ff;
   assign den_mag  = den_ff[16] ? (17'd0 - den_ff) : den_ff;
   assign quot_neg = product_ff[33] ^ den_ff[16];

   lco_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (prod_mag[31:0]),
      .divisor  (den_mag[15:0]),
      .negate   (quot_neg),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign q16     = (den_ff == 17'sd0) ? 16'd0 : div_quot;
   assign new_val = base_ff + $signed(q16);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x1_ff      <= in_start_x;
         y1_ff      <= in_start_y;
         x2_ff      <= in_end_x;
         y2_ff      <= in_end_y;
         visible_ff <= 1'b1;
      end else begin
         if (cmd.mark_reject) begin
            visible_ff <= 1'b0;
         end
         if (cmd.writeback) begin
            if (first_ff) begin
               x1_ff <= axis_y_ff ? new_val : edge_ff;
               y1_ff <= axis_y_ff ? edge_ff : new_val;
            end else begin
               x2_ff <= axis_y_ff ? new_val : edge_ff;
               y2_ff <= axis_y_ff ? edge_ff : new_val;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.load) begin
         count_ff <= '0;
      end else if (cmd.writeback) begin
         count_ff <= count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         res_visible_ff <= visible_ff;
         res_sx_ff      <= visible_ff ? x1_ff : 16'sd0;
         res_sy_ff      <= visible_ff ? y1_ff : 16'sd0;
         res_ex_ff      <= visible_ff ? x2_ff : 16'sd0;
         res_ey_ff      <= visible_ff ? y2_ff : 16'sd0;
      end
   end

   assign status.codes_clear = (c1 | c2) == 4'd0;
   assign status.reject      = (c1 & c2) != 4'd0;
   assign status.budget_done = count_ff == lco_pkg::CLIP_CNT_W'(lco_pkg::MAX_CLIPS);
   assign status.div_busy    = div_busy;
   assign status.div_done    = div_done;
   assign status.clips_used  = count_ff;

   assign out_visible = res_visible_ff;
   assign out_start_x = res_sx_ff;
   assign out_start_y = res_sy_ff;
   assign out_end_x   = res_ex_ff;
   assign out_end_y   = res_ey_ff;

endmodule
`default_nettype wire

// ===== src/lco_ctrl.sv =====
// Controller state machine: sequences the clip steps and the item handshakes.
`default_nettype none
module lco_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   input  wire lco_pkg::dp_status_type  status,
   output lco_pkg::ctrl_cmd_type        cmd
);

   lco_pkg::ctrl_state_type state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lco_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      req_ready    = 1'b0;
      unique case (state_ff)
         lco_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = lco_pkg::ST_CHECK;
            end
         end
         lco_pkg::ST_CHECK: begin
            priority if (status.codes_clear || status.budget_done) begin
               state_in = lco_pkg::ST_DONE;
            end else if (status.reject) begin
               cmd.mark_reject = 1'b1;
               state_in        = lco_pkg::ST_DONE;
            end else begin
               cmd.setup = 1'b1;
               state_in  = lco_pkg::ST_MUL;
            end
         end
         lco_pkg::ST_MUL: begin
            cmd.mult = 1'b1;
            state_in = lco_pkg::ST_DIV_GO;
         end
         lco_pkg::ST_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = lco_pkg::ST_DIV_WAIT;
         end
         lco_pkg::ST_DIV_WAIT: begin
            if (status.div_done) begin
               state_in = lco_pkg::ST_WRITE;
            end
         end
         lco_pkg::ST_WRITE: begin
            cmd.writeback = 1'b1;
            state_in      = lco_pkg::ST_CHECK;
         end
         lco_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = lco_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lco_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== src/line_clip_outcode.sv =====
// Top level of the line clip outcode block: Cohen-Sutherland segment clipping.
//
// req_ch carries one segment item (start_x, start_y, end_x, end_y); rsp_ch returns
// one item per segment: visible and the clipped endpoints (all zero when rejected).
// The clip window is four signed registers written through csr_write_enable,
// csr_index and csr_write_data (left, right, top, bottom). Write them only while
// idle; the block itself does not enforce it. One segment is processed at a time.
// Each clip step runs the outcode check and operand setup, a 17x17 multiply, then
// a serial divider, one bit a cycle, and the write back. At most MAX_CLIPS = 4
// clip steps are made per item before its result is loaded for rsp.
// The clip steps and the receiver set the rate: a new item is taken the cycle
// after the previous result is loaded into the output register.
// The output register holds a finished result while the receiver stalls; the
// next item is accepted meanwhile, and its result waits in the last state until
// the output register frees up.
// Reset (synchronous, active high) empties the output, returns to idle and sets
// the window to left 0, right 127, top 0, bottom 63.
`default_nettype none
module line_clip_outcode (
   input  wire logic                              clock,
   input  wire logic                              reset,
   lco_req_if.sink                                req_ch,
   lco_rsp_if.source                              rsp_ch,
   input  wire logic                              csr_write_enable,
   input  wire logic [lco_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [lco_pkg::COORD_W-1:0]       csr_write_data
);

   lco_pkg::ctrl_cmd_type  ctrl_cmd;
   lco_pkg::dp_status_type dp_status;
   logic                   req_ready_w;
   logic                   rsp_valid_w;

   lco_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready_w),
      .rsp_valid (rsp_valid_w),
      .rsp_ready (rsp_ch.ready),
      .status    (dp_status),
      .cmd       (ctrl_cmd)
   );

   lco_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (ctrl_cmd),
      .status           (dp_status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .in_start_x       (req_ch.start_x),
      .in_start_y       (req_ch.start_y),
      .in_end_x         (req_ch.end_x),
      .in_end_y         (req_ch.end_y),
      .out_visible      (rsp_ch.visible),
      .out_start_x      (rsp_ch.clip_start_x),
      .out_start_y      (rsp_ch.clip_start_y),
      .out_end_x        (rsp_ch.clip_end_x),
      .out_end_y        (rsp_ch.clip_end_y)
   );

   assign req_ch.ready = req_ready_w;
   assign rsp_ch.valid = rsp_valid_w;

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.div_start |-> !dp_status.div_busy)
      else $error("divider started while busy");

   a_clip_budget: assert property (@(posedge clock) disable iff (reset)
      dp_status.clips_used <= lco_pkg::CLIP_CNT_W'(lco_pkg::MAX_CLIPS))
      else $error("clip count beyond budget");

   a_div_to_write: assert property (@(posedge clock) disable iff (reset)
      dp_status.div_done |=> ctrl_cmd.writeback)
      else $error("quotient not written back");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_w && !rsp_ch.visible) |-> (rsp_ch.clip_start_x == 16'sd0 &&
         rsp_ch.clip_start_y == 16'sd0 && rsp_ch.clip_end_x == 16'sd0 &&
         rsp_ch.clip_end_y == 16'sd0))
      else $error("rejected item with nonzero endpoints");

endmodule
`default_nettype wire

// ===== tb/line_clip_outcode_test.sv =====
// Testbench for line_clip_outcode: directed and random segments checked against a clip predictor.
`timescale 1ns / 1ps
module line_clip_outcode_test;

   typedef struct packed {
      logic signed [lco_pkg::COORD_W-1:0] start_x;
      logic signed [lco_pkg::COORD_W-1:0] start_y;
      logic signed [lco_pkg::COORD_W-1:0] end_x;
      logic signed [lco_pkg::COORD_W-1:0] end_y;
   } segment_type;

   typedef struct packed {
      logic                               visible;
      logic signed [lco_pkg::COORD_W-1:0] clip_start_x;
      logic signed [lco_pkg::COORD_W-1:0] clip_start_y;
      logic signed [lco_pkg::COORD_W-1:0] clip_end_x;
      logic signed [lco_pkg::COORD_W-1:0] clip_end_y;
   } clip_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                            csr_write_enable;
   logic [lco_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [lco_pkg::COORD_W-1:0]     csr_write_data;

   lco_req_if req_ch ();
   lco_rsp_if rsp_ch ();

   line_clip_outcode dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // window as the block should currently hold it
   int win_left   = 0;
   int win_right  = 127;
   int win_top    = 0;
   int win_bottom = 63;

   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int mismatch_count = 0;

   clip_result_type clip_expected[$];

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic logic [3:0] region_code(int x, int y);
      logic [3:0] c;
      c = '0;
      if (x < win_left) c = lco_pkg::OC_LEFT;
      else if (x > win_right) c = lco_pkg::OC_RIGHT;
      if (y > win_bottom) c = c | lco_pkg::OC_BOTTOM;
      else if (y < win_top) c = c | lco_pkg::OC_TOP;
      return c;
   endfunction

   // base + num * mul / den, truncated toward zero, wrapped to 16 bits
   function automatic int edge_cross(int base, longint num, longint mul, longint den);
      longint q;
      logic signed [lco_pkg::COORD_W-1:0] w;
      q = (den != 0) ? (num * mul) / den : 64'sd0;
      w = base + q;
      return w;
   endfunction

   function automatic clip_result_type clip_segment(segment_type s);
      int x1, y1, x2, y2, x, y, clips;
      longint dx, dy;
      logic [3:0] c1, c2, c;
      clip_result_type r;
      x1 = s.start_x;
      y1 = s.start_y;
      x2 = s.end_x;
      y2 = s.end_y;
      c1 = region_code(x1, y1);
      c2 = region_code(x2, y2);
      clips = 0;
      r = '0;
      while ((c1 | c2) != 4'd0 && clips < lco_pkg::MAX_CLIPS) begin
         clips++;
         if ((c1 & c2) != 4'd0) return r;
         dx = longint'(x2) - x1;
         dy = longint'(y2) - y1;
         c = (c1 != 4'd0) ? c1 : c2;
         if ((c & lco_pkg::OC_TOP) != 4'd0) begin
            y = win_top;
            x = edge_cross(x1, dx, longint'(y) - y1, dy);
         end else if ((c & lco_pkg::OC_LEFT) != 4'd0) begin
            x = win_left;
            y = edge_cross(y1, dy, longint'(x) - x1, dx);
         end else if ((c & lco_pkg::OC_RIGHT) != 4'd0) begin
            x = win_right;
            y = edge_cross(y1, dy, longint'(x) - x1, dx);
         end else begin
            y = win_bottom;
            x = edge_cross(x1, dx, longint'(y) - y1, dy);
         end
         if (c1 != 4'd0) begin
            x1 = x;
            y1 = y;
            c1 = region_code(x, y);
         end else begin
            x2 = x;
            y2 = y;
            c2 = region_code(x, y);
         end
      end
      r.visible      = 1'b1;
      r.clip_start_x = x1;
      r.clip_start_y = y1;
      r.clip_end_x   = x2;
      r.clip_end_y   = y2;
      return r;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      if (mismatch_count <= 100)
         $display("mismatch %s: got %0d expected %0d at %0t ns", what, got, want, $time);
   endtask

   task automatic check_field(input string what, input int got, input int want);
      if (got != want) report_mismatch(what, got, want);
   endtask

   always @(posedge clock) begin : result_monitor
      clip_result_type want;
      segment_type seg;
      if (!reset) begin
         // pop before push: a result accepted here belongs to an earlier item
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (clip_expected.size() == 0) begin
               report_mismatch("result with no segment pending", rsp_ch.visible, 0);
            end else begin
               want = clip_expected.pop_front();
               check_field("visible", rsp_ch.visible, want.visible);
               check_field("clip_start_x", rsp_ch.clip_start_x, want.clip_start_x);
               check_field("clip_start_y", rsp_ch.clip_start_y, want.clip_start_y);
               check_field("clip_end_x", rsp_ch.clip_end_x, want.clip_end_x);
               check_field("clip_end_y", rsp_ch.clip_end_y, want.clip_end_y);
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            seg.start_x = req_ch.start_x;
            seg.start_y = req_ch.start_y;
            seg.end_x   = req_ch.end_x;
            seg.end_y   = req_ch.end_y;
            clip_expected.push_back(clip_segment(seg));
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= (int'($urandom_range(99)) >= rsp_stall_pct);
      end
   end

   // ---------------------------------------------------------------- driving

   task automatic send_segment(input int sx, input int sy, input int ex, input int ey);
      while (int'($urandom_range(99)) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.start_x <= sx[lco_pkg::COORD_W-1:0];
      req_ch.start_y <= sy[lco_pkg::COORD_W-1:0];
      req_ch.end_x   <= ex[lco_pkg::COORD_W-1:0];
      req_ch.end_y   <= ey[lco_pkg::COORD_W-1:0];
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (clip_expected.size() != 0);
      @(posedge clock);
   endtask

   task automatic csr_write(input logic [lco_pkg::CSR_INDEX_W-1:0] index, input int value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value[lco_pkg::COORD_W-1:0];
      @(posedge clock);
   endtask

   // only called with the block idle
   task automatic set_window(input int l, input int r, input int t, input int b);
      csr_write(lco_pkg::CSR_WINDOW_LEFT, l);
      csr_write(lco_pkg::CSR_WINDOW_RIGHT, r);
      csr_write(lco_pkg::CSR_WINDOW_TOP, t);
      csr_write(lco_pkg::CSR_WINDOW_BOTTOM, b);
      csr_write_enable <= 1'b0;
      win_left   = l;
      win_right  = r;
      win_top    = t;
      win_bottom = b;
   endtask

   // ---------------------------------------------------------------- random helpers

   function automatic int rand16();
      return int'($urandom_range(65535)) - 32768;
   endfunction

   function automatic int clamp16(int v);
      if (v < -32768) return -32768;
      if (v > 32767) return 32767;
      return v;
   endfunction

   // mostly near the window so that clipping really happens
   function automatic int pick_coord(int lo, int hi);
      int a, b, m;
      a = (lo < hi) ? lo : hi;
      b = (lo < hi) ? hi : lo;
      m = (b - a) / 2 + 16;
      case ($urandom_range(9))
         0, 1: return rand16();
         2: begin
            case ($urandom_range(3))
               0: return -32768;
               1: return 32767;
               2: return clamp16(lo - 1 + int'($urandom_range(2)));
               default: return clamp16(hi - 1 + int'($urandom_range(2)));
            endcase
         end
         default: return clamp16(a - m + int'($urandom_range(b - a + 2 * m)));
      endcase
   endfunction

   function automatic int pick_extreme();
      return ($urandom_range(1) != 0) ? 32767 : -32768;
   endfunction

   task automatic pick_window();
      int l, r, t, b;
      case ($urandom_range(7))
         0: begin
            l = 0; r = 127; t = 0; b = 63;
         end
         1: begin
            l = -32768; r = 32767; t = -32768; b = 32767;
         end
         2: begin
            l = rand16(); r = rand16(); t = rand16(); b = rand16();
         end
         3: begin
            l = pick_extreme(); r = pick_extreme(); t = pick_extreme(); b = pick_extreme();
         end
         4: begin
            // degenerate point or line windows, or two by two
            l = rand16() / 64; r = l + int'($urandom_range(1));
            t = rand16() / 64; b = t + int'($urandom_range(1));
         end
         5: begin
            // inverted
            r = rand16() / 8; l = r + 1 + int'($urandom_range(300));
            b = rand16() / 8; t = b + 1 + int'($urandom_range(300));
         end
         default: begin
            l = int'($urandom_range(60000)) - 30000;
            r = clamp16(l + int'($urandom_range(2000)));
            t = int'($urandom_range(60000)) - 30000;
            b = clamp16(t + int'($urandom_range(2000)));
         end
      endcase
      set_window(l, r, t, b);
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_reset_window();
      send_segment(10, 10, 100, 50);
      send_segment(-5, 10, -20, 30);
      send_segment(200, 5, 130, 60);
      send_segment(10, 64, 100, 100);
      send_segment(10, -1, 100, -50);
      send_segment(50, -20, 50, 30);
      send_segment(-40, 20, 60, 30);
      send_segment(60, 30, 300, 40);
      send_segment(20, 10, 40, 200);
      send_segment(-32768, -32768, 32767, 32767);
      send_segment(32767, -32768, -32768, 32767);
      send_segment(-32768, 32767, 32767, -32768);
   endtask

   task automatic test_window_extremes();
      wait_drained();
      set_window(-32768, 32767, -32768, 32767);
      send_segment(-32768, -32768, 32767, 32767);
      send_segment(32767, 32767, 32767, 32767);
      wait_drained();
      set_window(32767, 32767, -32768, -32768);
      send_segment(-32768, -32768, 32767, -32768);
      send_segment(-32768, 32767, 32767, -32768);
      wait_drained();
      // single point window: one segment is rejected after rounding, one shrinks to the point
      set_window(5, 5, 5, 5);
      send_segment(0, 0, 10, 11);
      send_segment(0, 5, 10, 5);
   endtask

   task automatic test_inverted_window();
      wait_drained();
      set_window(100, 0, 0, 63);
      send_segment(150, 10, -50, 20);
      send_segment(50, 0, 60, 10);
      wait_drained();
      set_window(0, 127, 50, -50);
      send_segment(10, 100, 20, -100);
      wait_drained();
      set_window(32767, -32768, 32767, -32768);
      send_segment(0, 0, 100, 100);
      send_segment(-32768, 32767, 32767, -32768);
   endtask

   task automatic test_random_segments(input int count, input int idle_pct, input int stall_pct);
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int n = 0; n < count; n++) begin
         if (n % 38 == 0) begin
            wait_drained();
            pick_window();
         end
         send_segment(pick_coord(win_left, win_right), pick_coord(win_top, win_bottom),
                      pick_coord(win_left, win_right), pick_coord(win_top, win_bottom));
      end
   endtask

   initial begin
      req_ch.valid     = 1'b0;
      req_ch.start_x   = '0;
      req_ch.start_y   = '0;
      req_ch.end_x     = '0;
      req_ch.end_y     = '0;
      rsp_ch.ready     = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = lco_pkg::CSR_WINDOW_LEFT;
      csr_write_data   = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      req_idle_pct  = 37;
      rsp_stall_pct = 56;
      test_reset_window();
      test_window_extremes();
      test_inverted_window();
      test_random_segments(342, 37, 56);
      test_random_segments(342, 56, 37);
      test_random_segments(342, 0, 0);
      wait_drained();
      repeat (160) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("line_clip_outcode_test OK");
      end else begin
         $display("line_clip_outcode_test NOT OK");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("line_clip_outcode_test NOT OK");
      $finish;
   end

endmodule
